// ----- rtl/hfm_pkg.sv -----
`default_nettype none

package hfm_pkg;

	// Field and register widths
	localparam int IDX_W    = 10;
	localparam int DIM_W    = 11;
	localparam int CTR_W    = 10;
	localparam int GAIN_W   = 16;
	localparam int STEEP_W  = 10;
	localparam int CUTOFF_W = 8;

	// Largest plane edge; bigger register values are clamped to it
	localparam logic [DIM_W-1:0] MAX_DIM = 11'd1024;

	// Gain format: unsigned Q4.12
	localparam int GAIN_FRAC_BITS = 12;

	// Datapath widths
	localparam int SQ_W        = 2 * IDX_W;          // one squared offset
	localparam int R2_W        = SQ_W + 1;           // squared radius
	localparam int NUM_W       = STEEP_W + R2_W;     // c10 * r2
	localparam int D0SQ_W      = 2 * CUTOFF_W;       // D0^2
	localparam int XQ_INT_BITS = 4;                  // x < 16 once not saturated
	localparam int DEN_W       = D0SQ_W + XQ_INT_BITS; // 10 * D0^2 < 16 * D0^2
	localparam int Q16         = 16;
	localparam int XQ_W        = Q16 + XQ_INT_BITS;  // x in Q16
	localparam int Y_W         = 21;                 // x * log2(e) in Q16, below 24.0
	localparam int N_W         = Y_W - Q16;          // integer part of y
	localparam int P_W         = Q16 + 1;            // 2^-f in Q16, up to 1.0

	localparam logic [Q16-1:0] ROUND_Q16 = 16'h8000;
	localparam logic [P_W-1:0] LOG2E_Q16 = 17'd94548;

	// Taylor polynomial for 2^-f, highest order first, Horner form
	localparam int HORNER_STEPS = 6;
	localparam logic [P_W-1:0] EXP2_COEF [HORNER_STEPS+1] = '{
		17'd10, 17'd87, 17'd630, 17'd3638, 17'd15743, 17'd45426, 17'd65536
	};

	// Register reset values
	localparam logic [GAIN_W-1:0]   GAMMA_HIGH_RST = GAIN_W'(2 << GAIN_FRAC_BITS);
	localparam logic [GAIN_W-1:0]   GAMMA_LOW_RST  = GAIN_W'((2 << GAIN_FRAC_BITS) / 10);
	localparam logic [STEEP_W-1:0]  STEEP_MIN      = 10'd10;
	localparam logic [STEEP_W-1:0]  STEEP_RST      = 10'd10;
	localparam logic [CUTOFF_W-1:0] CUTOFF_RST     = 8'd5;
	localparam logic [DIM_W-1:0]    PLANE_RST      = 11'd512;

	// Configuration port
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	typedef enum logic [2:0] {
		REG_GAMMA_HIGH = 3'd0,
		REG_GAMMA_LOW  = 3'd1,
		REG_STEEPNESS  = 3'd2,
		REG_CUTOFF     = 3'd3,
		REG_PLANE_ROWS = 3'd4,
		REG_PLANE_COLS = 3'd5
	} reg_idx_t;

	// Settings as the datapath sees them (clamped / derived)
	typedef struct packed {
		logic [GAIN_W-1:0]  gamma_high;
		logic [GAIN_W-1:0]  gamma_low;
		logic [STEEP_W-1:0] c10;
		logic [DEN_W-1:0]   den;
		logic [CTR_W-1:0]   row_ctr;
		logic [CTR_W-1:0]   col_ctr;
	} cfg_t;

	// Center coordinate of one plane axis, after clamping the edge length
	function automatic logic [CTR_W-1:0] plane_center(input logic [DIM_W-1:0] dim);
		logic [DIM_W-1:0] lim;
		lim = (dim > MAX_DIM) ? MAX_DIM : dim;
		return lim[DIM_W-1:1];
	endfunction

endpackage

`default_nettype wire

// ----- rtl/hfm_cfg.sv -----
`default_nettype none

module hfm_cfg import hfm_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	output cfg_t                    cfg
);

	logic [GAIN_W-1:0]   gamma_high_q;
	logic [GAIN_W-1:0]   gamma_low_q;
	logic [STEEP_W-1:0]  steep_q;
	logic [CUTOFF_W-1:0] cutoff_q;
	logic [DIM_W-1:0]    rows_q;
	logic [DIM_W-1:0]    cols_q;
	logic [STEEP_W-1:0]  c10_q;
	logic [D0SQ_W-1:0]   d0sq_q;
	logic [DEN_W-1:0]    den_q;

	logic                wr_en;
	reg_idx_t            reg_idx;
	logic [CUTOFF_W-1:0] d0;

	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign pready  = 1'b1;

	// Register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_high_q <= GAMMA_HIGH_RST;
			gamma_low_q  <= GAMMA_LOW_RST;
			steep_q      <= STEEP_RST;
			cutoff_q     <= CUTOFF_RST;
			rows_q       <= PLANE_RST;
			cols_q       <= PLANE_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_GAMMA_HIGH: gamma_high_q <= pwdata[GAIN_W-1:0];
				REG_GAMMA_LOW:  gamma_low_q  <= pwdata[GAIN_W-1:0];
				REG_STEEPNESS:  steep_q      <= pwdata[STEEP_W-1:0];
				REG_CUTOFF:     cutoff_q     <= pwdata[CUTOFF_W-1:0];
				REG_PLANE_ROWS: rows_q       <= pwdata[DIM_W-1:0];
				REG_PLANE_COLS: cols_q       <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_GAMMA_HIGH: prdata = PDATA_W'(gamma_high_q);
			REG_GAMMA_LOW:  prdata = PDATA_W'(gamma_low_q);
			REG_STEEPNESS:  prdata = PDATA_W'(steep_q);
			REG_CUTOFF:     prdata = PDATA_W'(cutoff_q);
			REG_PLANE_ROWS: prdata = PDATA_W'(rows_q);
			REG_PLANE_COLS: prdata = PDATA_W'(cols_q);
			default:        prdata = '0;
		endcase
	end

	// Derived terms; consumed several stages down the pipe, so a register or two is free
	assign d0 = (cutoff_q == '0) ? CUTOFF_W'(1) : cutoff_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c10_q  <= STEEP_RST;
			d0sq_q <= D0SQ_W'(CUTOFF_RST) * D0SQ_W'(CUTOFF_RST);
			den_q  <= DEN_W'(10) * DEN_W'(CUTOFF_RST) * DEN_W'(CUTOFF_RST);
		end else begin
			c10_q  <= (steep_q < STEEP_MIN) ? STEEP_MIN : steep_q;
			d0sq_q <= D0SQ_W'(d0) * D0SQ_W'(d0);
			// 10 * D0^2 as shift-add
			den_q  <= (DEN_W'(d0sq_q) << 3) + (DEN_W'(d0sq_q) << 1);
		end
	end

	// Centers are needed in the very first stage, so they come straight from the registers
	always_comb begin
		cfg.gamma_high = gamma_high_q;
		cfg.gamma_low  = gamma_low_q;
		cfg.c10        = c10_q;
		cfg.den        = den_q;
		cfg.row_ctr    = plane_center(rows_q);
		cfg.col_ctr    = plane_center(cols_q);
	end

endmodule

`default_nettype wire

// ----- rtl/hfm_radius.sv -----
`default_nettype none

module hfm_radius import hfm_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic [IDX_W-1:0]   row_index,
	input  wire logic [IDX_W-1:0]   col_index,
	input  wire logic [CTR_W-1:0]   row_ctr,
	input  wire logic [CTR_W-1:0]   col_ctr,
	input  wire logic [STEEP_W-1:0] c10,
	output logic                    out_valid,
	output logic [NUM_W-1:0]        num
);

	logic              vld_s1, vld_s2, vld_s3, vld_s4;
	logic [IDX_W-1:0]  dr_s1, dc_s1;
	logic [SQ_W-1:0]   sqr_s2, sqc_s2;
	logic [R2_W-1:0]   r2_s3;
	logic [NUM_W-1:0]  num_s4;

	function automatic logic [IDX_W-1:0] abs_off(input logic [IDX_W-1:0] idx,
		input logic [CTR_W-1:0] ctr);
		logic [IDX_W-1:0] c;
		c = IDX_W'(ctr);
		return (idx >= c) ? idx - c : c - idx;
	endfunction

	// Valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// s1 offsets, s2 squares, s3 radius^2, s4 scaled by steepness
	always_ff @(posedge clk) begin
		dr_s1  <= abs_off(row_index, row_ctr);
		dc_s1  <= abs_off(col_index, col_ctr);
		sqr_s2 <= SQ_W'(dr_s1) * SQ_W'(dr_s1);
		sqc_s2 <= SQ_W'(dc_s1) * SQ_W'(dc_s1);
		r2_s3  <= R2_W'(sqr_s2) + R2_W'(sqc_s2);
		num_s4 <= NUM_W'(c10) * NUM_W'(r2_s3);
	end

	assign out_valid = vld_s4;
	assign num       = num_s4;

endmodule

`default_nettype wire

// ----- rtl/hfm_div.sv -----
`default_nettype none

module hfm_div import hfm_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  out_valid,
	output logic                  sat,
	output logic [XQ_W-1:0]       xq
);

	typedef struct packed {
		logic             valid;
		logic             sat;
		logic [DEN_W-1:0] rem;
		logic [XQ_W-1:0]  lo;
		logic [XQ_W-1:0]  quo;
	} div_stage_t;

	// Index 0 is the entry register, then one quotient bit per stage
	div_stage_t stg_s [XQ_W+1];

	logic       over;
	div_stage_t entry;

	// Entry: flag x >= 16, seed the remainder with num / 16 (below den when not flagged)
	always_comb begin
		over        = num >= NUM_W'({den, XQ_INT_BITS'(0)});
		entry.valid = in_valid;
		entry.sat   = over;
		entry.rem   = over ? '0 : num[DEN_W+XQ_INT_BITS-1:XQ_INT_BITS];
		entry.lo    = {num[XQ_INT_BITS-1:0], Q16'(0)};
		entry.quo   = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_s[0] <= '0;
		end else begin
			stg_s[0] <= entry;
		end
	end

	// Restoring divide, MSB first
	for (genvar k = 0; k < XQ_W; k++) begin : g_stage
		logic [DEN_W:0] trial;
		logic [DEN_W:0] diff;
		logic           fits;
		div_stage_t     nxt;

		always_comb begin
			trial     = {stg_s[k].rem, stg_s[k].lo[XQ_W-1]};
			diff      = trial - {1'b0, den};
			fits      = trial >= {1'b0, den};
			nxt       = stg_s[k];
			nxt.rem   = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			nxt.lo    = {stg_s[k].lo[XQ_W-2:0], 1'b0};
			nxt.quo   = {stg_s[k].quo[XQ_W-2:0], fits};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				stg_s[k+1] <= '0;
			end else begin
				stg_s[k+1] <= nxt;
			end
		end
	end

	assign out_valid = stg_s[XQ_W].valid;
	assign sat       = stg_s[XQ_W].sat;
	assign xq        = stg_s[XQ_W].quo;

endmodule

`default_nettype wire

// ----- rtl/hfm_exp.sv -----
`default_nettype none

module hfm_exp import hfm_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic            sat,
	input  wire logic [XQ_W-1:0] xq,
	output logic                 out_valid,
	output logic [P_W-1:0]       e
);

	localparam int YP_W  = XQ_W + P_W;   // x * log2(e) product
	localparam int HP_W  = P_W + Q16;    // Horner product
	localparam int SUM_W = P_W + 7;      // p plus rounding half, n up to 23

	typedef struct packed {
		logic             valid;
		logic             sat;
		logic [N_W-1:0]   n;
		logic [Q16-1:0]   f;
		logic [P_W-1:0]   p;
	} hst_t;

	logic [YP_W-1:0] yprod;
	hst_t            seed;
	hst_t            hst_s [HORNER_STEPS+1];
	logic            vld_s8;
	logic [P_W-1:0]  e_s8;

	// y = x * log2(e), split into integer n and fraction f
	always_comb begin
		yprod      = YP_W'(xq) * YP_W'(LOG2E_Q16) + YP_W'(ROUND_Q16);
		seed.valid = in_valid;
		seed.sat   = sat;
		seed.n     = yprod[Q16+Y_W-1:2*Q16];
		seed.f     = yprod[2*Q16-1:Q16];
		seed.p     = EXP2_COEF[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hst_s[0] <= '0;
		end else begin
			hst_s[0] <= seed;
		end
	end

	// One Horner step per stage: p = c_k - round(p * f)
	for (genvar k = 1; k <= HORNER_STEPS; k++) begin : g_horner
		logic [HP_W-1:0] prod;
		hst_t            nxt;

		always_comb begin
			prod  = HP_W'(hst_s[k-1].p) * HP_W'(hst_s[k-1].f) + HP_W'(ROUND_Q16);
			nxt   = hst_s[k-1];
			nxt.p = EXP2_COEF[k] - prod[HP_W-1:Q16];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				hst_s[k] <= '0;
			end else begin
				hst_s[k] <= nxt;
			end
		end
	end

	// Scale by 2^-n with round to nearest
	logic [SUM_W-1:0] half;
	logic [SUM_W-1:0] sum;
	logic [SUM_W-1:0] scaled;

	always_comb begin
		half   = (hst_s[HORNER_STEPS].n == '0) ? '0 :
			(SUM_W'(1) << (hst_s[HORNER_STEPS].n - N_W'(1)));
		sum    = SUM_W'(hst_s[HORNER_STEPS].p) + half;
		scaled = sum >> hst_s[HORNER_STEPS].n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else begin
			vld_s8 <= hst_s[HORNER_STEPS].valid;
		end
	end

	always_ff @(posedge clk) begin
		e_s8 <= hst_s[HORNER_STEPS].sat ? '0 : scaled[P_W-1:0];
	end

	assign out_valid = vld_s8;
	assign e         = e_s8;

endmodule

`default_nettype wire

// ----- rtl/hfm_blend.sv -----
`default_nettype none

module hfm_blend import hfm_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [P_W-1:0]    e,
	input  wire logic [GAIN_W-1:0] gamma_high,
	input  wire logic [GAIN_W-1:0] gamma_low,
	output logic                   done,
	output logic [GAIN_W-1:0]      filter_gain
);

	localparam logic [P_W-1:0] E_ONE = P_W'(1) << Q16;
	localparam int BP_W = GAIN_W + P_W;

	logic              vld_s1, vld_s2, vld_s3;
	logic [P_W-1:0]    m_s1;
	logic [GAIN_W-1:0] t_s2;
	logic [GAIN_W-1:0] gain_s3;

	logic              inverted;
	logic [GAIN_W-1:0] span;
	logic [BP_W-1:0]   prod;

	// Gain span; a low gain above the high gain gives an inverted mask
	always_comb begin
		inverted = gamma_high < gamma_low;
		span     = inverted ? gamma_low - gamma_high : gamma_high - gamma_low;
		prod     = BP_W'(span) * BP_W'(m_s1) + BP_W'(ROUND_Q16);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// s1 mask 1 - exp(-x), s2 scaled span, s3 offset by the low gain
	always_ff @(posedge clk) begin
		m_s1    <= E_ONE - e;
		t_s2    <= prod[GAIN_W+Q16-1:Q16];
		gain_s3 <= inverted ? gamma_low - t_s2 : gamma_low + t_s2;
	end

	assign done        = vld_s3;
	assign filter_gain = gain_s3;

endmodule

`default_nettype wire

// ----- rtl/homomorphic_filter_mask_generator.sv -----
// Homomorphic filter gain generator (Gaussian high-emphasis). Each beat on start with
// row_index/col_index returns the Q4.12 gain gamma_low + (gamma_high - gamma_low) *
// (1 - exp(-c * D^2 / D0^2)) for that bin, D measured from the plane center. The block
// is fully pipelined: busy never rises, a new coordinate is taken every cycle, and each
// result shows on filter_gain with done high for exactly one cycle. The path holds 36
// register stages, the first loaded by the edge that took start: 4 of distance math, 21
// of divide for D^2 / D0^2 (an entry register, then one quotient bit per stage), 8 of
// exponential and 3 of gain blending. Results cannot be held off, so the receiver must
// take every done beat.
// Registers (APB, byte address 4*i): gamma_high, gamma_low, steepness_tenths,
// cutoff_radius, plane_rows, plane_cols; write them only while no beat is in flight.
`default_nettype none

module homomorphic_filter_mask_generator import hfm_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [IDX_W-1:0]   row_index,
	input  wire logic [IDX_W-1:0]   col_index,
	output logic                    done,
	output logic      [GAIN_W-1:0]  filter_gain
);

	cfg_t             cfg;
	logic             accept;
	logic             rad_valid;
	logic [NUM_W-1:0] num;
	logic             div_valid;
	logic             div_sat;
	logic [XQ_W-1:0]  xq;
	logic             exp_valid;
	logic [P_W-1:0]   e;

	// Pipeline never stalls
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	hfm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	hfm_radius u_radius (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.row_index (row_index),
		.col_index (col_index),
		.row_ctr   (cfg.row_ctr),
		.col_ctr   (cfg.col_ctr),
		.c10       (cfg.c10),
		.out_valid (rad_valid),
		.num       (num)
	);

	hfm_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rad_valid),
		.num       (num),
		.den       (cfg.den),
		.out_valid (div_valid),
		.sat       (div_sat),
		.xq        (xq)
	);

	hfm_exp u_exp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid),
		.sat       (div_sat),
		.xq        (xq),
		.out_valid (exp_valid),
		.e         (e)
	);

	hfm_blend u_blend (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (exp_valid),
		.e           (e),
		.gamma_high  (cfg.gamma_high),
		.gamma_low   (cfg.gamma_low),
		.done        (done),
		.filter_gain (filter_gain)
	);

endmodule

`default_nettype wire

// ----- tb/tb_homomorphic_filter_mask_generator.sv -----
`timescale 1ns / 100ps

module tb_homomorphic_filter_mask_generator import hfm_pkg::*;;

	localparam int PIPE_LAT   = 35;
	localparam int IDLE_LIMIT = 4000;
	localparam int RAND_PHASES = 12;
	localparam int PHASE_BINS  = 112;

	// 2^-f polynomial, highest order first
	localparam longint unsigned EXP2_POLY [7] = '{10, 87, 630, 3638, 15743, 45426, 65536};

	typedef struct {
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
	} coord_t;

	typedef struct {
		logic [GAIN_W-1:0] gain;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
	} gain_exp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// APB side
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	// Coordinate / gain side
	logic               start = 1'b0;
	logic               busy;
	logic [IDX_W-1:0]   row_index = '0;
	logic [IDX_W-1:0]   col_index = '0;
	logic               done;
	logic [GAIN_W-1:0]  filter_gain;

	// Register shadow copy used by the predictor
	logic [GAIN_W-1:0]   cfg_gh = 16'd8192;
	logic [GAIN_W-1:0]   cfg_gl = 16'd819;
	logic [STEEP_W-1:0]  cfg_steep = 10'd10;
	logic [CUTOFF_W-1:0] cfg_cutoff = 8'd5;
	logic [DIM_W-1:0]    cfg_rows = 11'd512;
	logic [DIM_W-1:0]    cfg_cols = 11'd512;

	coord_t      coord_q[$];
	gain_exp_t   gain_q[$];
	coord_t      next_coord;
	gain_exp_t   exp_gain;
	int unsigned gap_left = 0;
	bit          gaps_on = 1'b1;
	logic        start_nxt;
	int unsigned coords_taken = 0;
	int unsigned gains_checked = 0;
	int unsigned mismatch_cnt = 0;
	int unsigned settings_cnt = 0;
	int unsigned idle_cycles = 0;

	homomorphic_filter_mask_generator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.start       (start),
		.busy        (busy),
		.row_index   (row_index),
		.col_index   (col_index),
		.done        (done),
		.filter_gain (filter_gain)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Squared offset of one coordinate from the (clamped) plane center
	function automatic longint unsigned axis_dist_sq(input logic [IDX_W-1:0] idx,
			input logic [DIM_W-1:0] dim);
		longint unsigned lim, ctr, d;
		lim = (dim > 1024) ? 1024 : dim;
		ctr = lim >> 1;
		d = (idx >= ctr) ? idx - ctr : ctr - idx;
		return d * d;
	endfunction

	// Gain at one bin under the current register copy
	function automatic logic [GAIN_W-1:0] predict_gain(input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c);
		longint unsigned c10, d0, num, den, xq, y, f, p, e, half, m, span, g;
		int unsigned n;
		c10 = (cfg_steep < 10) ? 10 : cfg_steep;
		d0 = (cfg_cutoff < 1) ? 1 : cfg_cutoff;
		num = c10 * (axis_dist_sq(r, cfg_rows) + axis_dist_sq(c, cfg_cols));
		den = 10 * d0 * d0;
		if (num >= 16 * den) begin
			e = 0;
		end else begin
			xq = (num << 16) / den;
			y = (xq * 94548 + 32768) >> 16;
			n = 32'(y >> 16);
			f = y & 64'hFFFF;
			p = EXP2_POLY[0];
			for (int k = 1; k < 7; k++)
				p = EXP2_POLY[k] - ((p * f + 32768) >> 16);
			if (n >= 40) begin
				e = 0;
			end else begin
				half = (n == 0) ? 0 : (64'd1 << (n - 1));
				e = (p + half) >> n;
			end
		end
		m = 65536 - e;
		if (cfg_gh >= cfg_gl) begin
			span = cfg_gh - cfg_gl;
			g = cfg_gl + ((span * m + 32768) >> 16);
		end else begin
			// inverted mask
			span = cfg_gl - cfg_gh;
			g = cfg_gl - ((span * m + 32768) >> 16);
		end
		return g[GAIN_W-1:0];
	endfunction

	// Mostly back-to-back, some short gaps, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// One APB write: setup, access, done when pready seen
	task automatic write_reg(input logic [2:0] idx, input logic [PDATA_W-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_GAMMA_HIGH: cfg_gh = val[GAIN_W-1:0];
			REG_GAMMA_LOW:  cfg_gl = val[GAIN_W-1:0];
			REG_STEEPNESS:  cfg_steep = val[STEEP_W-1:0];
			REG_CUTOFF:     cfg_cutoff = val[CUTOFF_W-1:0];
			REG_PLANE_ROWS: cfg_rows = val[DIM_W-1:0];
			REG_PLANE_COLS: cfg_cols = val[DIM_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_setting(input logic [GAIN_W-1:0] gh, input logic [GAIN_W-1:0] gl,
			input logic [STEEP_W-1:0] st, input logic [CUTOFF_W-1:0] co,
			input logic [DIM_W-1:0] nr, input logic [DIM_W-1:0] nc);
		write_reg(REG_GAMMA_HIGH, PDATA_W'(gh));
		write_reg(REG_GAMMA_LOW,  PDATA_W'(gl));
		write_reg(REG_STEEPNESS,  PDATA_W'(st));
		write_reg(REG_CUTOFF,     PDATA_W'(co));
		write_reg(REG_PLANE_ROWS, PDATA_W'(nr));
		write_reg(REG_PLANE_COLS, PDATA_W'(nc));
		settings_cnt++;
		@(negedge clk);
	endtask

	task automatic queue_coord(input int unsigned r, input int unsigned c);
		coord_t item;
		item.row = IDX_W'(r);
		item.col = IDX_W'(c);
		coord_q.insert(coord_q.size(), item);
	endtask

	// Wait for every queued bin to be taken and its gain returned
	task automatic settle();
		@(negedge clk);
		while (coord_q.size() > 0 || start || gain_q.size() > 0)
			@(negedge clk);
		repeat (PIPE_LAT + 5) @(negedge clk);
	endtask

	// Stimulus
	initial begin : stim
		logic [GAIN_W-1:0]   gh, gl;
		logic [STEEP_W-1:0]  st;
		logic [CUTOFF_W-1:0] co;
		logic [DIM_W-1:0]    nr, nc;
		int unsigned pick, span, rc, cc;
		coord_t item;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// writes to unused register slots must leave the reset values alone
		write_reg(3'd6, $urandom());
		write_reg(3'd7, $urandom());
		@(negedge clk);

		// reset settings: center, just off center, corners
		queue_coord(256, 256);
		queue_coord(256, 257);
		queue_coord(258, 256);
		queue_coord(260, 259);
		queue_coord(0, 0);
		queue_coord(1023, 1023);
		queue_coord(0, 1023);
		queue_coord(1023, 0);
		settle();

		// steepness below one, cutoff zero, planes larger than the max
		apply_setting(16'd8192, 16'd819, 10'd3, 8'd0, 11'd2047, 11'd1100);
		queue_coord(512, 512);
		queue_coord(512, 513);
		queue_coord(513, 514);
		queue_coord(0, 0);
		queue_coord(1023, 1023);
		settle();

		// low gain above high gain
		apply_setting(16'd819, 16'd8192, 10'd10, 8'd5, 11'd512, 11'd512);
		queue_coord(256, 256);
		queue_coord(258, 259);
		queue_coord(262, 256);
		queue_coord(0, 1023);
		settle();

		// full gain span, sharpest transition, widest cutoff, tiny plane;
		// index far outside the plane
		apply_setting(16'hFFFF, 16'h0000, 10'd1023, 8'd255, 11'd2, 11'd3);
		queue_coord(1, 1);
		queue_coord(0, 0);
		queue_coord(40, 30);
		queue_coord(1023, 1023);
		settle();

		// equal gains, smallest cutoff, degenerate plane edges
		apply_setting(16'd4096, 16'd4096, 10'd600, 8'd1, 11'd0, 11'd1);
		queue_coord(0, 0);
		queue_coord(1, 0);
		queue_coord(1023, 512);
		settle();

		// random settings, half the bins near the center where exp is live
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			pick = $urandom_range(0, 99);
			gh = (pick < 10) ? 16'hFFFF : (pick < 15) ? 16'h0000 : 16'($urandom_range(0, 65535));
			pick = $urandom_range(0, 99);
			gl = (pick < 10) ? 16'h0000 : (pick < 15) ? 16'hFFFF : 16'($urandom_range(0, 65535));
			pick = $urandom_range(0, 99);
			st = (pick < 15) ? 10'($urandom_range(0, 9)) :
				(pick < 25) ? 10'd1023 : 10'($urandom_range(10, 600));
			pick = $urandom_range(0, 99);
			co = (pick < 10) ? 8'd0 : (pick < 20) ? 8'd255 : 8'($urandom_range(1, 200));
			pick = $urandom_range(0, 99);
			nr = (pick < 10) ? 11'($urandom_range(1025, 2047)) :
				(pick < 20) ? 11'($urandom_range(0, 3)) : 11'($urandom_range(2, 1024));
			pick = $urandom_range(0, 99);
			nc = (pick < 10) ? 11'($urandom_range(1025, 2047)) :
				(pick < 20) ? 11'($urandom_range(0, 3)) : 11'($urandom_range(2, 1024));
			apply_setting(gh, gl, st, co, nr, nc);
			gaps_on = (ph % 3) != 0;

			span = 4 * ((cfg_cutoff == 0) ? 1 : cfg_cutoff) + 3;
			rc = ((cfg_rows > 1024) ? 1024 : cfg_rows) >> 1;
			cc = ((cfg_cols > 1024) ? 1024 : cfg_cols) >> 1;
			for (int k = 0; k < PHASE_BINS; k++) begin
				if ($urandom_range(0, 1)) begin
					item.row = IDX_W'(rc + $urandom_range(0, 2 * span) - span);
					item.col = IDX_W'(cc + $urandom_range(0, 2 * span) - span);
				end else begin
					item.row = IDX_W'($urandom_range(0, 1023));
					item.col = IDX_W'($urandom_range(0, 1023));
				end
				coord_q.insert(coord_q.size(), item);
			end
			settle();
		end

		$display("Drove %0d bins through %0d register settings (plus reset values).",
			coords_taken, settings_cnt);
		$display("Compared %0d gains, %0d mismatches.", gains_checked, mismatch_cnt);
		if (mismatch_cnt == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Driver: predict on each accepted beat, then present the next bin
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
			gap_left = 0;
		end else begin
			if (start && !busy) begin
				gain_q.insert(gain_q.size(), gain_exp_t'{predict_gain(row_index, col_index),
					row_index, col_index});
				coords_taken++;
			end
			if (!start || !busy) begin
				start_nxt = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (coord_q.size() > 0) begin
					next_coord = coord_q.pop_front();
					row_index <= next_coord.row;
					col_index <= next_coord.col;
					start_nxt = 1'b1;
					gap_left = gaps_on ? pick_gap() : 0;
				end
				start <= start_nxt;
			end
		end
	end

	// Monitor: each done beat against the oldest predicted gain
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (gain_q.size() == 0) begin
				$display("%0t: gain beat with none pending: expected none, actual %h",
					$time, filter_gain);
				mismatch_cnt++;
			end else begin
				exp_gain = gain_q.pop_front();
				gains_checked++;
				if (filter_gain !== exp_gain.gain) begin
					$display("%0t: bin (%0d,%0d) gain expected %h actual %h", $time,
						exp_gain.row, exp_gain.col, exp_gain.gain, filter_gain);
					mismatch_cnt++;
				end
			end
		end
	end

	// Watchdog on cycles with no beat of any kind
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done === 1'b1 || (psel && penable))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no progress for %0d cycles, %0d gains outstanding", $time,
				idle_cycles, gain_q.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

endmodule
